>>> sv/kwh_pkg.sv
package kwh_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned OLEN_W  = 8;
  localparam int unsigned KW_COUNT = 12;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_IDENT  = 4'd0;
  localparam kind_t KIND_IF     = 4'd1;
  localparam kind_t KIND_ENUM   = 4'd2;
  localparam kind_t KIND_FOR    = 4'd3;
  localparam kind_t KIND_WHILE  = 4'd4;
  localparam kind_t KIND_VOID   = 4'd5;
  localparam kind_t KIND_BOOL   = 4'd6;
  localparam kind_t KIND_CHAR   = 4'd7;
  localparam kind_t KIND_INT    = 4'd8;
  localparam kind_t KIND_FLOAT  = 4'd9;
  localparam kind_t KIND_DOUBLE = 4'd10;
  localparam kind_t KIND_RETURN = 4'd11;
  localparam kind_t KIND_ELSE   = 4'd12;

  typedef struct packed {
    logic flush;
    logic begin_req;
  } in_user_t;

  typedef struct packed {
    logic [6:0]        pad;
    logic              length_clipped;
    logic [OLEN_W-1:0] word_length;
    logic [HASH_W-1:0] word_hash;
  } out_data_t;

  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [CH_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-CH_W){1'b0}}, b};
    return x * FNV_PRIME;
  endfunction

  // text right-justified, first character in the highest used byte
  function automatic logic [HASH_W-1:0] fnv_text(input logic [47:0] txt,
                                                 input int unsigned n);
    logic [HASH_W-1:0] h;
    h = FNV_BASIS;
    for (int unsigned i = 0; i < n; i++) begin
      h = fnv_step(h, txt[8*(n-1-i) +: 8]);
    end
    return h;
  endfunction

  localparam logic [HASH_W-1:0] KW_HASH [KW_COUNT] = '{
    fnv_text(48'("if"), 2),
    fnv_text(48'("enum"), 4),
    fnv_text(48'("for"), 3),
    fnv_text(48'("while"), 5),
    fnv_text(48'("void"), 4),
    fnv_text(48'("bool"), 4),
    fnv_text(48'("char"), 4),
    fnv_text(48'("int"), 3),
    fnv_text(48'("float"), 5),
    fnv_text(48'("double"), 6),
    fnv_text(48'("return"), 6),
    fnv_text(48'("else"), 4)
  };

  function automatic kind_t classify(input logic [HASH_W-1:0] h);
    kind_t k;
    k = KIND_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (KW_HASH[i] == h) begin
        k = KIND_W'(i + 1);
      end
    end
    return k;
  endfunction

  function automatic logic is_word_byte(input logic [CH_W-1:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           (c >= "0" && c <= "9") || (c == "_");
  endfunction

endpackage

>>> sv/keyword_hash_recognizer_top.sv
// channel   dir  tdata                          tuser
// s_axis    in   ch[7:0]                        begin_req[0] flush[1]
// m_axis    out  word_hash[31:0] word_length    kind[3:0]
//                [39:32] length_clipped[40]
// one input beat per cycle unless stalled; the beat that closes a word passes the
// input register, then the word's result goes to the result register
// the hash loop is one xor and one constant multiply on the running hash
// rst_ni clears the word state to the offset basis and empties both stages
// a stalled result holds the pipeline; s_axis_tready stays high while the
// result register is free or being taken
module keyword_hash_recognizer_top #(
  parameter int unsigned LENGTH_MAX = 255
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // ch
  input  kwh_pkg::in_user_t           s_axis_tuser,   // begin_req, flush
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output kwh_pkg::out_data_t          m_axis_tdata,   // word_hash, word_length,
                                                      // length_clipped, zero pad
  output kwh_pkg::kind_t              m_axis_tuser    // kind
);
  import kwh_pkg::*;

  localparam int unsigned LEN_W = $clog2(LENGTH_MAX + 1);

  logic              in_vld_q, in_vld_d;
  logic [CH_W-1:0]   in_ch_q;
  in_user_t          in_user_q;

  logic              open_q, open_d;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              ovf_q, ovf_d;

  logic              out_vld_q, out_vld_d;
  out_data_t         out_data_q;
  kind_t             out_kind_q;

  logic advance;
  logic take_in;
  logic emit;

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;
  assign in_vld_d      = take_in ? 1'b1 : (advance ? 1'b0 : in_vld_q);

  always_comb begin
    open_d = open_q;
    hash_d = hash_q;
    len_d  = len_q;
    ovf_d  = ovf_q;
    emit   = 1'b0;
    if (in_vld_q && advance) begin
      if (in_user_q.flush) begin
        if (open_q) begin
          emit   = 1'b1;
          open_d = 1'b0;
          hash_d = FNV_BASIS;
          len_d  = '0;
          ovf_d  = 1'b0;
        end
      end else if (in_user_q.begin_req) begin
        emit   = open_q;
        open_d = 1'b1;
        hash_d = fnv_step(FNV_BASIS, in_ch_q);
        len_d  = LEN_W'(1);
        ovf_d  = 1'b0;
      end else if (open_q) begin
        if (is_word_byte(in_ch_q)) begin
          hash_d = fnv_step(hash_q, in_ch_q);
          if (len_q < LEN_W'(LENGTH_MAX)) begin
            len_d = len_q + LEN_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end else begin
          emit   = 1'b1;
          open_d = 1'b0;
          hash_d = FNV_BASIS;
          len_d  = '0;
          ovf_d  = 1'b0;
        end
      end
    end
  end

  assign out_vld_d = emit ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      open_q    <= 1'b0;
      hash_q    <= FNV_BASIS;
      len_q     <= '0;
      ovf_q     <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      open_q    <= open_d;
      hash_q    <= hash_d;
      len_q     <= len_d;
      ovf_q     <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_ch_q   <= s_axis_tdata;
      in_user_q <= s_axis_tuser;
    end
    if (emit) begin
      out_data_q.pad            <= '0;
      out_data_q.length_clipped <= ovf_q;
      out_data_q.word_length    <= OLEN_W'(len_q);
      out_data_q.word_hash      <= hash_q;
      out_kind_q                <= classify(hash_q);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

>>> dv/keyword_hash_recognizer_checker.sv
`timescale 1ns / 1ps

module keyword_hash_recognizer_checker #(
  parameter int unsigned LENGTH_MAX = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [7:0]         s_tdata_i,     // ch
  input  kwh_pkg::in_user_t  s_tuser_i,     // begin_req, flush
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  kwh_pkg::out_data_t m_tdata_i,     // word_hash, word_length, length_clipped
  input  kwh_pkg::kind_t     m_tuser_i,     // kind
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  import kwh_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [31:0] hash;
    logic [7:0]  len;
    logic        clipped;
  } word_result_t;

  string kw_name [KW_COUNT] = '{"if", "enum", "for", "while", "void", "bool",
                                "char", "int", "float", "double", "return", "else"};
  kind_t kw_kind [KW_COUNT] = '{KIND_IF, KIND_ENUM, KIND_FOR, KIND_WHILE, KIND_VOID,
                                KIND_BOOL, KIND_CHAR, KIND_INT, KIND_FLOAT, KIND_DOUBLE,
                                KIND_RETURN, KIND_ELSE};

  logic         in_word;
  logic [31:0]  acc_hash;
  int unsigned  acc_len;
  logic         acc_clip;
  word_result_t word_q [$];
  word_result_t oldest;

  function automatic logic [31:0] fnv1a(input logic [31:0] h, input logic [7:0] b);
    logic [63:0] prod;
    prod = 64'(h ^ {24'd0, b}) * 64'(FNV_PRIME);
    return prod[31:0];
  endfunction

  function automatic kind_t kind_of(input logic [31:0] h);
    logic [31:0] kh;
    for (int k = 0; k < KW_COUNT; k++) begin
      kh = FNV_BASIS;
      for (int j = 0; j < kw_name[k].len(); j++) begin
        kh = fnv1a(kh, kw_name[k][j]);
      end
      if (kh == h) begin
        return kw_kind[k];
      end
    end
    return KIND_IDENT;
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
           (c >= 8'h30 && c <= 8'h39) || (c == 8'h5f);
  endfunction

  task automatic clear_word();
    in_word  = 1'b0;
    acc_hash = FNV_BASIS;
    acc_len  = 0;
    acc_clip = 1'b0;
  endtask

  task automatic take_byte(input logic [7:0] c);
    acc_hash = fnv1a(acc_hash, c);
    if (acc_len < LENGTH_MAX) begin
      acc_len++;
    end else begin
      acc_clip = 1'b1;
    end
  endtask

  task automatic close_word();
    word_result_t w;
    w.kind    = kind_of(acc_hash);
    w.hash    = acc_hash;
    w.len     = acc_len[7:0];
    w.clipped = acc_clip;
    word_q.push_back(w);
    clear_word();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_word();
      word_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (word_q.size() == 0) begin
          $error("result beat with no word pending: word_hash %h", m_tdata_i.word_hash);
          fail_count_o++;
        end else begin
          oldest = word_q.pop_front();
          if (m_tuser_i !== oldest.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", oldest.kind, m_tuser_i);
            fail_count_o++;
          end
          if (m_tdata_i.word_hash !== oldest.hash) begin
            $error("word_hash mismatch: expected %h, actual %h", oldest.hash,
                   m_tdata_i.word_hash);
            fail_count_o++;
          end
          if (m_tdata_i.word_length !== oldest.len) begin
            $error("word_length mismatch: expected %0d, actual %0d", oldest.len,
                   m_tdata_i.word_length);
            fail_count_o++;
          end
          if (m_tdata_i.length_clipped !== oldest.clipped) begin
            $error("length_clipped mismatch: expected %0d, actual %0d", oldest.clipped,
                   m_tdata_i.length_clipped);
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i.flush) begin
          if (in_word) close_word();
        end else if (s_tuser_i.begin_req) begin
          if (in_word) close_word();
          in_word = 1'b1;
          take_byte(s_tdata_i);
        end else if (in_word) begin
          if (is_ident_char(s_tdata_i)) begin
            take_byte(s_tdata_i);
          end else begin
            close_word();
          end
        end
      end
      pending_o = word_q.size();
    end
  end

endmodule

>>> dv/keyword_hash_recognizer_top_tb.sv
`timescale 1ns / 1ps

module keyword_hash_recognizer_top_tb;
  import kwh_pkg::*;

  localparam int unsigned ITEM_TARGET = 600;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;   // ch
  in_user_t   s_axis_tuser  = '0;      // begin_req, flush
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  out_data_t  m_axis_tdata;            // word_hash, word_length, length_clipped, pad
  kind_t      m_axis_tuser;            // kind

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;

  string kw_list [KW_COUNT] = '{"if", "enum", "for", "while", "void", "bool",
                                "char", "int", "float", "double", "return", "else"};

  always #1 clk_i = ~clk_i;

  keyword_hash_recognizer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  keyword_hash_recognizer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  initial begin
    #1000000;
    $display("keyword_hash_recognizer_top_tb failed");
    $finish;
  end

  // receiver: rotating stall modes plus one long hold-off
  initial begin
    int unsigned cyc;
    logic        rdy;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      if (cyc >= 400 && cyc < 480) begin
        rdy = 1'b0;
      end else begin
        case ((cyc / 48) % 4)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = ($urandom_range(0, 4) != 0);
        endcase
      end
      m_axis_tready <= rdy;
      cyc++;
    end
  end

  task automatic send_byte(input logic [7:0] ch, input logic b, input logic f);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= '{flush: f, begin_req: b};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_word(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == 0, 1'b0);
    end
  endtask

  function automatic logic [7:0] rand_ident();
    int unsigned r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    if (r < 62) return 8'h30 + 8'(r - 52);
    return 8'h5f;
  endfunction

  function automatic logic [7:0] rand_sep();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 47));
      1: return 8'($urandom_range(58, 64));
      2: return ($urandom_range(0, 1) == 1) ? 8'h60 : 8'($urandom_range(91, 94));
      default: return 8'($urandom_range(123, 255));
    endcase
  endfunction

  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned long_words;
    long_words = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_word("if");
    send_byte(8'h20, 1'b0, 1'b0);
    send_word("return");
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hff, 1'b0, 1'b1);
    send_word("else");
    send_word("x_9Z");
    send_byte(8'h71, 1'b1, 1'b1);
    send_byte(8'h71, 1'b0, 1'b0);
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'h7f, 1'b0, 1'b0);
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);

    // random
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        if (long_words < 2 && items_sent >= 150 + 200 * long_words) begin
          len = (long_words == 0) ? $urandom_range(256, 262) : $urandom_range(254, 256);
          long_words++;
          send_byte(rand_ident(), 1'b1, 1'b0);
          repeat (len - 1) send_byte(rand_ident(), 1'b0, 1'b0);
        end else if (pick < 30) begin
          send_word(kw_list[$urandom_range(0, KW_COUNT - 1)]);
          if ($urandom_range(0, 5) == 0) send_byte(rand_ident(), 1'b0, 1'b0);
        end else begin
          send_byte(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : rand_ident(),
                    1'b1, 1'b0);
          repeat ($urandom_range(0, 12)) send_byte(rand_ident(), 1'b0, 1'b0);
        end
        case ($urandom_range(0, 3))
          0, 1: send_byte(rand_sep(), 1'b0, 1'b0);
          2: send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
          default: ;
        endcase
      end else begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0,
                  $urandom_range(0, 6) == 0);
      end
    end
    s_axis_tvalid <= 1'b0;

    @(negedge clk_i);
    while (pending_words != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("keyword_hash_recognizer_top_tb passed");
    end else begin
      $display("keyword_hash_recognizer_top_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/kwh_pkg.sv
sv/keyword_hash_recognizer_top.sv
dv/keyword_hash_recognizer_checker.sv
dv/keyword_hash_recognizer_top_tb.sv
